// File: rtl/core/rlpt_pkg.sv
// ---------------------------------------------------------------------------
// rlpt_pkg
// shared types, register indexes and constants of the rate limited pid throttle
// ---------------------------------------------------------------------------
`default_nettype none

package rlpt_pkg;

    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_INDEX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH    = 32;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_TIME     = 3'd3,
        REG_DRY_MAX  = 3'd4,
        REG_FULL_MAX = 3'd5,
        REG_THR_MIN  = 3'd6
    } reg_index_t;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_SEED   = 4'd0,
        OP_STEP   = 4'd1,
        OP_RAMP   = 4'd2,
        OP_ERR    = 4'd3,
        OP_INTMUL = 4'd4,
        OP_INTACC = 4'd5,
        OP_DIFF   = 4'd6,
        OP_DIV    = 4'd7,
        OP_PMUL   = 4'd8,
        OP_IMUL   = 4'd9,
        OP_DMUL   = 4'd10,
        OP_CLAMP  = 4'd11,
        OP_NONE   = 4'd12
    } dp_op_t;

    typedef struct packed {
        logic   load;
        logic   start;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic seeded;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/rate_limited_pid_throttle_unit.sv
// ---------------------------------------------------------------------------
// rate_limited_pid_throttle_unit
// rate limited pid throttle controller, signed fixed point
// ---------------------------------------------------------------------------
// One request is taken at a time and yields one throttle command (signed
// Q16.16 at the defaults); the single bit-serial multiply/divide unit runs
// five multiplies and one divide per request in turn, between the ramp,
// error, integral, difference and clamp steps, which do not use it.
// The input stays stalled while a request is in work and while a finished
// command waits stalled in the output register; the next request can be
// taken in the cycle the waiting command is accepted.
`default_nettype none

module rate_limited_pid_throttle_unit
    import rlpt_pkg::*;
#(
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [31:0]          measured_speed,
    input  wire logic signed [31:0]          target_speed,
    input  wire logic [30:0]                 accel_limit,
    input  wire logic signed [31:0]          trim_level,
    input  wire logic                        reheat_on,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [31:0]               throttle_out
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic signed [31:0] result;
    logic signed [31:0] out_reg;

    rlpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rlpt_datapath #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .measured_speed (measured_speed),
        .target_speed   (target_speed),
        .accel_limit    (accel_limit),
        .trim_level     (trim_level),
        .reheat_on      (reheat_on),
        .cmd            (cmd),
        .status         (status),
        .result         (result)
    );

    // result register, loaded when the clamp completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (cmd.load && cmd.op == OP_CLAMP)
            out_reg <= result;
    end

    assign throttle_out = out_reg;

    // a request is never taken while the sequencer is working
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> in_stall)
        else $error("request accepted while unit busy");

    // after an accepted request the ramp is seeded
    a_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> status.seeded)
        else $error("ramp not seeded after request");

    // the unit is never started while already running
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !status.busy)
        else $error("unit started while busy");

endmodule

`default_nettype wire

// File: rtl/core/rlpt_datapath.sv
// ---------------------------------------------------------------------------
// rlpt_datapath
// state registers, serial multiplier and divider, saturating adder and clamps
// ---------------------------------------------------------------------------
`default_nettype none

module rlpt_datapath
    import rlpt_pkg::*;
#(
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]   cfg_data,
    input  wire logic signed [31:0]          measured_speed,
    input  wire logic signed [31:0]          target_speed,
    input  wire logic [30:0]                 accel_limit,
    input  wire logic signed [31:0]          trim_level,
    input  wire logic                        reheat_on,
    input  wire dp_cmd_t                     cmd,
    output dp_status_t                       status,
    output logic signed [31:0]               result
);

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int PW = 2 * W;
    localparam int NW = W + F;
    localparam int CW = $clog2(NW + 1);
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam longint IB_L = ((longint'(1) << F) * 2 + 5) / 10;
    localparam logic signed [W-1:0] IBOUND = W'(IB_L);

    function automatic logic signed [W-1:0] sat_ext(input logic signed [32:0] v);
        logic signed [W+32:0] e;
        e = (W + 33)'(v);
        if (e > (W + 33)'(VMAX)) return VMAX;
        if (e < (W + 33)'(VMIN)) return VMIN;
        return W'(e);
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = (W + 1)'(a) + (W + 1)'(b);
        if (s > (W + 1)'(VMAX)) return VMAX;
        if (s < (W + 1)'(VMIN)) return VMIN;
        return W'(s);
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = (W + 1)'(a) - (W + 1)'(b);
        if (s > (W + 1)'(VMAX)) return VMAX;
        if (s < (W + 1)'(VMIN)) return VMIN;
        return W'(s);
    endfunction

    // saturate a magnitude with sign
    function automatic logic signed [W-1:0] from_mag(input logic neg,
                                                     input logic [NW-1:0] m);
        logic [NW-1:0] lim;
        lim = neg ? NW'(VMAX) + NW'(1) : NW'(VMAX);
        if (m > lim) return neg ? VMIN : VMAX;
        return neg ? W'(-m) : W'(m);
    endfunction

    // configuration and state
    logic signed [W-1:0] gain_p_reg, gain_i_reg, gain_d_reg, time_reg;
    logic signed [W-1:0] dry_reg, full_reg, min_reg;
    logic signed [W-1:0] integ_reg, prev_reg, ramp_reg;
    logic                seeded_reg;
    logic signed [W-1:0] meas_reg, targ_reg, accel_reg, trim_reg;
    logic                reheat_reg;
    logic signed [W-1:0] step_reg, err_reg, diff_reg, deriv_reg, thr_reg, prod_reg;

    // serial unit: shift-add multiplier or restoring divider
    logic                busy_reg, div_mode_reg, neg_reg;
    logic [CW-1:0]       cnt_reg;
    logic [W-1:0]        mb_reg;
    logic [PW-1:0]       acc_reg, ma_reg;
    logic [NW-1:0]       num_reg, quo_reg;
    logic [W:0]          rem_reg;
    logic [W-1:0]        dv_reg;

    logic signed [W-1:0] dt;
    logic signed [W-1:0] op_a, op_b;
    logic [W-1:0]        ua, ub;
    logic [W:0]          rem_sh;
    logic [PW-1:0]       shifted;
    logic [NW-1:0]       mag_res;
    logic signed [W-1:0] unit_res;
    logic signed [W-1:0] neg_step, upper, clamped;
    logic                dp_neg;

    assign dt = (time_reg > 0) ? time_reg : W'(1);
    assign rem_sh = {rem_reg[W-1:0], num_reg[NW-1]};
    assign shifted = acc_reg >> F;
    assign mag_res = (shifted[PW-1:NW] != '0) ? {NW{1'b1}} : shifted[NW-1:0];
    assign unit_res = div_mode_reg ? from_mag(neg_reg, quo_reg) : from_mag(neg_reg, mag_res);
    assign neg_step = -step_reg;
    assign upper = reheat_reg ? full_reg : dry_reg;
    assign dp_neg = diff_reg[W-1];

    always_comb
    begin
        case (cmd.op)
            OP_STEP:   begin op_a = accel_reg;  op_b = dt;        end
            OP_INTMUL: begin op_a = err_reg;    op_b = dt;        end
            OP_PMUL:   begin op_a = gain_p_reg; op_b = err_reg;   end
            OP_IMUL:   begin op_a = gain_i_reg; op_b = integ_reg; end
            OP_DMUL:   begin op_a = gain_d_reg; op_b = deriv_reg; end
            default:   begin op_a = diff_reg;   op_b = dt;        end
        endcase
        ua = op_a[W-1] ? W'(-op_a) : W'(op_a);
        ub = op_b[W-1] ? W'(-op_b) : W'(op_b);
        clamped = (thr_reg > upper) ? upper : thr_reg;
        if (clamped < min_reg)
            clamped = min_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            time_reg   <= W'(655);
            dry_reg    <= W'(65536);
            full_reg   <= W'(65536);
            min_reg    <= '0;
            integ_reg  <= '0;
            prev_reg   <= '0;
            ramp_reg   <= '0;
            seeded_reg <= 1'b0;
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_P:   gain_p_reg <= sat_ext({cfg_data[31], cfg_data});
                    REG_GAIN_I:   gain_i_reg <= sat_ext({cfg_data[31], cfg_data});
                    REG_GAIN_D:   gain_d_reg <= sat_ext({cfg_data[31], cfg_data});
                    REG_TIME:     time_reg   <= sat_ext({2'b00, cfg_data[30:0]});
                    REG_DRY_MAX:  dry_reg    <= sat_ext({cfg_data[31], cfg_data});
                    REG_FULL_MAX: full_reg   <= sat_ext({cfg_data[31], cfg_data});
                    REG_THR_MIN:  min_reg    <= sat_ext({cfg_data[31], cfg_data});
                    default:      ;
                endcase
            end
            if (busy_reg)
            begin
                if (div_mode_reg)
                begin
                    if (rem_sh >= {1'b0, dv_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, dv_reg};
                        quo_reg <= {quo_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[NW-2:0], 1'b0};
                    end
                    num_reg <= num_reg << 1;
                end
                else
                begin
                    if (mb_reg[0])
                        acc_reg <= acc_reg + ma_reg;
                    ma_reg <= ma_reg << 1;
                    mb_reg <= mb_reg >> 1;
                end
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
            else if (cmd.start)
            begin
                busy_reg <= 1'b1;
                div_mode_reg <= (cmd.op == OP_DIV);
                if (cmd.op == OP_DIV)
                begin
                    neg_reg <= dp_neg;
                    num_reg <= {ua, {F{1'b0}}};
                    quo_reg <= '0;
                    rem_reg <= '0;
                    dv_reg  <= W'(dt);
                    cnt_reg <= CW'(NW);
                end
                else
                begin
                    neg_reg <= op_a[W-1] ^ op_b[W-1];
                    acc_reg <= '0;
                    ma_reg  <= PW'(ua);
                    mb_reg  <= ub;
                    cnt_reg <= CW'(W);
                end
            end
            if (cmd.load)
            begin
                case (cmd.op)
                    OP_SEED:
                    begin
                        meas_reg   <= sat_ext({measured_speed[31], measured_speed});
                        targ_reg   <= sat_ext({target_speed[31], target_speed});
                        accel_reg  <= sat_ext({2'b00, accel_limit});
                        trim_reg   <= sat_ext({trim_level[31], trim_level});
                        reheat_reg <= reheat_on;
                        if (!seeded_reg)
                            ramp_reg <= sat_ext({measured_speed[31], measured_speed});
                        seeded_reg <= 1'b1;
                    end
                    OP_STEP: step_reg <= unit_res;
                    OP_RAMP:
                    begin
                        if (ssub(targ_reg, ramp_reg) > step_reg)
                            ramp_reg <= sadd(ramp_reg, step_reg);
                        else if (ssub(targ_reg, ramp_reg) < neg_step)
                            ramp_reg <= ssub(ramp_reg, step_reg);
                        else
                            ramp_reg <= targ_reg;
                    end
                    OP_ERR:
                    begin
                        err_reg <= ssub(ramp_reg, meas_reg);
                        thr_reg <= trim_reg;
                    end
                    OP_INTMUL: prod_reg <= unit_res;
                    OP_INTACC:
                    begin
                        if (sadd(integ_reg, prod_reg) > IBOUND)
                            integ_reg <= IBOUND;
                        else if (sadd(integ_reg, prod_reg) < -IBOUND)
                            integ_reg <= -IBOUND;
                        else
                            integ_reg <= sadd(integ_reg, prod_reg);
                    end
                    OP_DIFF:
                    begin
                        diff_reg <= ssub(err_reg, prev_reg);
                        prev_reg <= err_reg;
                    end
                    OP_DIV:  deriv_reg <= unit_res;
                    OP_PMUL: thr_reg <= sadd(thr_reg, unit_res);
                    OP_IMUL: thr_reg <= sadd(thr_reg, unit_res);
                    OP_DMUL: thr_reg <= sadd(thr_reg, unit_res);
                    OP_CLAMP: thr_reg <= clamped;
                    default: ;
                endcase
            end
        end
    end

    assign status.busy   = busy_reg;
    assign status.seeded = seeded_reg;
    // clamped command, valid during the clamp step
    assign result        = 32'(clamped);

endmodule

`default_nettype wire

// File: rtl/core/rlpt_ctrl.sv
// ---------------------------------------------------------------------------
// rlpt_ctrl
// sequencer stepping the datapath through one control tick
// ---------------------------------------------------------------------------
`default_nettype none

module rlpt_ctrl
    import rlpt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_WAIT  = 6'b000100,
        S_LOAD  = 6'b001000,
        S_PLAIN = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    dp_op_t op_reg, op_next;
    logic   out_valid_reg, out_valid_next;

    function automatic logic is_unit(input dp_op_t o);
        return o == OP_STEP || o == OP_INTMUL || o == OP_DIV ||
               o == OP_PMUL || o == OP_IMUL || o == OP_DMUL;
    endfunction

    function automatic dp_op_t next_op(input dp_op_t o);
        case (o)
            OP_SEED:   return OP_STEP;
            OP_STEP:   return OP_RAMP;
            OP_RAMP:   return OP_ERR;
            OP_ERR:    return OP_INTMUL;
            OP_INTMUL: return OP_INTACC;
            OP_INTACC: return OP_DIFF;
            OP_DIFF:   return OP_DIV;
            OP_DIV:    return OP_PMUL;
            OP_PMUL:   return OP_IMUL;
            OP_IMUL:   return OP_DMUL;
            OP_DMUL:   return OP_CLAMP;
            default:   return OP_NONE;
        endcase
    endfunction

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.load       = 1'b0;
        cmd.start      = 1'b0;
        cmd.op         = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.op = OP_SEED;
                if (in_valid && !in_stall)
                begin
                    cmd.load   = 1'b1;
                    op_next    = OP_STEP;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
                if (!status.busy)
                    state_next = S_LOAD;
            S_LOAD, S_PLAIN:
            begin
                cmd.load = 1'b1;
                op_next  = next_op(op_reg);
                if (op_reg == OP_CLAMP)
                    state_next = S_OUT;
                else if (is_unit(next_op(op_reg)))
                    state_next = S_START;
                else
                    state_next = S_PLAIN;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: verif/tb_rate_limited_pid_throttle_unit.sv
// ---------------------------------------------------------------------------
// tb_rate_limited_pid_throttle_unit
// self-checking bench for the rate limited pid throttle unit
// ---------------------------------------------------------------------------
// Drives requests over the valid/stall input channel and compares each
// throttle command against a fixed-point predictor that tracks the ramp,
// integral and derivative state. A directed table covers reset defaults,
// field extremes, crossed limits, a zero time step and saturation; random
// phases vary gains, limits and idling on both channels.
`default_nettype none

module tb_rate_limited_pid_throttle_unit;
    import rlpt_pkg::*;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam longint IBOUND = 64'sd13107;
    localparam int SETTLE = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] measured_speed = '0;
    logic signed [31:0] target_speed = '0;
    logic [30:0] accel_limit = '0;
    logic signed [31:0] trim_level = '0;
    logic reheat_on = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] throttle_out;

    always #1 clk = ~clk;

    rate_limited_pid_throttle_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .measured_speed(measured_speed), .target_speed(target_speed),
        .accel_limit(accel_limit), .trim_level(trim_level), .reheat_on(reheat_on),
        .out_valid(out_valid), .out_stall(out_stall), .throttle_out(throttle_out)
    );

    typedef struct {
        logic signed [31:0] meas;
        logic signed [31:0] target;
        logic [30:0]        accel;
        logic signed [31:0] trim;
        logic               reheat;
        bit                 has_fixed;
        logic signed [31:0] fixed_out;
    } speed_req_t;

    // predictor copy of the block
    longint kp, ki, kd, dt_reg, dry_max, full_max, thr_min;
    longint integ, prev_err, ramp;
    bit seeded;

    logic signed [31:0] throttle_q[$];
    int mismatches = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    bit hold_out = 1'b0;

    function automatic longint clip(input longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p < 0) p = -((-p) >>> 16);
        else p = p >>> 16;
        return clip(p);
    endfunction

    function automatic longint qdiv(input longint a, input longint d);
        longint m;
        logic [127:0] q;
        m = a < 0 ? -a : a;
        q = (128'(m) << 16) / 128'(d);
        if (a < 0) return q > 128'(-QMIN) ? QMIN : -longint'(q);
        return q > 128'(QMAX) ? QMAX : longint'(q);
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_GAIN_P:   kp = longint'(signed'(val));
            REG_GAIN_I:   ki = longint'(signed'(val));
            REG_GAIN_D:   kd = longint'(signed'(val));
            REG_TIME:     dt_reg = longint'(val[30:0]);
            REG_DRY_MAX:  dry_max = longint'(signed'(val));
            REG_FULL_MAX: full_max = longint'(signed'(val));
            REG_THR_MIN:  thr_min = longint'(signed'(val));
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] predict_throttle(input speed_req_t r);
        longint m, t, a, dt, delta, stp, cmd, err, der, thr, upper;
        m = r.meas;
        t = r.target;
        a = r.accel;
        dt = dt_reg > 0 ? dt_reg : 1;
        if (!seeded) begin
            ramp = m;
            seeded = 1'b1;
        end
        delta = clip(t - ramp);
        stp = qmul(a, dt);
        if (delta > stp) cmd = clip(ramp + stp);
        else if (delta < -stp) cmd = clip(ramp - stp);
        else cmd = t;
        ramp = cmd;
        err = clip(cmd - m);
        integ = clip(integ + qmul(err, dt));
        if (integ > IBOUND) integ = IBOUND;
        if (integ < -IBOUND) integ = -IBOUND;
        der = qdiv(clip(err - prev_err), dt);
        thr = clip(longint'(r.trim) + qmul(kp, err));
        thr = clip(thr + qmul(ki, integ));
        thr = clip(thr + qmul(kd, der));
        prev_err = err;
        upper = r.reheat ? full_max : dry_max;
        if (thr > upper) thr = upper;
        if (thr < thr_min) thr = thr_min;
        return thr[31:0];
    endfunction

    task automatic send_request(input speed_req_t r);
        logic signed [31:0] expv;
        if ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < in_idle_pct) @(posedge clk);
        end
        measured_speed <= r.meas;
        target_speed <= r.target;
        accel_limit <= r.accel;
        trim_level <= r.trim;
        reheat_on <= r.reheat;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expv = predict_throttle(r);
        if (r.has_fixed && expv !== r.fixed_out) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees: typed %0d predicted %0d", r.fixed_out, expv);
        end
        throttle_q.push_back(expv);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (throttle_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_q32();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic speed_req_t rand_req();
        speed_req_t r;
        r.meas = $urandom_range(3) == 0 ? rand_q32() : $urandom_range(2000000) - 1000000;
        r.target = $urandom_range(3) == 0 ? rand_q32() : $urandom_range(2000000) - 1000000;
        r.accel = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(3000000));
        r.trim = $urandom_range(2) == 0 ? rand_q32() : $urandom_range(40000) - 20000;
        r.reheat = $urandom_range(1);
        r.has_fixed = 1'b0;
        r.fixed_out = '0;
        return r;
    endfunction

    function automatic speed_req_t row(input logic [31:0] m, input logic [31:0] t,
                                       input logic [30:0] a, input logic [31:0] tr,
                                       input logic rh, input bit f,
                                       input logic [31:0] fo);
        speed_req_t r;
        r.meas = m; r.target = t; r.accel = a; r.trim = tr; r.reheat = rh;
        r.has_fixed = f; r.fixed_out = fo;
        return r;
    endfunction

    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            if (throttle_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected throttle %0d", throttle_out);
            end else begin
                if (throttle_out !== throttle_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("throttle mismatch: expected %0d actual %0d",
                                 throttle_q[0], throttle_out);
                end
                void'(throttle_q.pop_front());
            end
        end
        out_stall <= hold_out || ($urandom_range(99) < out_idle_pct);
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        speed_req_t dir_rows[$];
        int n;
        kp = 0; ki = 0; kd = 0; dt_reg = 655;
        dry_max = 65536; full_max = 65536; thr_min = 0;
        integ = 0; prev_err = 0; ramp = 0; seeded = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains give trim clamped to the limits
        dir_rows.push_back(row(32'd0, 32'd0, 31'd0, 32'd1000, 1'b0, 1, 32'd1000));
        dir_rows.push_back(row(32'h7fffffff, 32'h80000000, 31'h7fffffff, 32'h7fffffff,
                               1'b1, 1, 32'd65536));
        dir_rows.push_back(row(32'h80000000, 32'h7fffffff, 31'h7fffffff, 32'h80000000,
                               1'b0, 1, 32'd0));
        dir_rows.push_back(row(32'd5, 32'd5, 31'd0, 32'd70000, 1'b1, 1, 32'd65536));
        foreach (dir_rows[i]) send_request(dir_rows[i]);
        drain();

        write_reg(REG_GAIN_P, 32'h00010000);
        write_reg(REG_GAIN_I, 32'h00008000);
        write_reg(REG_GAIN_D, 32'h00000100);
        write_reg(REG_TIME, 32'd0);
        write_reg(REG_DRY_MAX, 32'h7fffffff);
        write_reg(REG_FULL_MAX, 32'h80000000);
        write_reg(REG_THR_MIN, 32'h80000000);
        dir_rows.delete();
        dir_rows.push_back(row(32'd100, 32'h7fffffff, 31'h7fffffff, 32'd0, 1'b0, 0, 0));
        dir_rows.push_back(row(32'h80000000, 32'h7fffffff, 31'h7fffffff, 32'd0, 1'b1, 0, 0));
        dir_rows.push_back(row(32'h7fffffff, 32'h80000000, 31'd1, 32'h7fffffff, 1'b0, 0, 0));
        dir_rows.push_back(row(32'h80000000, 32'h80000000, 31'd0, 32'h80000000, 1'b1, 0, 0));
        foreach (dir_rows[i]) send_request(dir_rows[i]);
        drain();

        // crossed limits
        write_reg(REG_TIME, 32'hffffffff);
        write_reg(REG_GAIN_P, 32'h7fffffff);
        write_reg(REG_GAIN_D, 32'h80000000);
        write_reg(REG_THR_MIN, 32'd50000);
        write_reg(REG_DRY_MAX, 32'd1000);
        write_reg(REG_FULL_MAX, 32'h80000000);
        dir_rows.delete();
        dir_rows.push_back(row(32'd0, 32'd1000, 31'd5, 32'd0, 1'b0, 1, 32'd50000));
        dir_rows.push_back(row(32'h7fffffff, 32'd0, 31'h7fffffff, 32'h80000000,
                               1'b1, 1, 32'd50000));
        foreach (dir_rows[i]) send_request(dir_rows[i]);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
                1: begin in_idle_pct = 66; out_idle_pct = 0;  end
                2: begin in_idle_pct = 0;  out_idle_pct = 66; end
                default: begin in_idle_pct = 29; out_idle_pct = 29; end
            endcase
            write_reg(REG_GAIN_P, $urandom_range(3) == 0 ? rand_q32()
                                  : $urandom_range(262144) - 131072);
            write_reg(REG_GAIN_I, $urandom_range(3) == 0 ? rand_q32()
                                  : $urandom_range(262144) - 131072);
            write_reg(REG_GAIN_D, $urandom_range(3) == 0 ? rand_q32()
                                  : $urandom_range(2000) - 1000);
            write_reg(REG_TIME, $urandom_range(2) == 0 ? $urandom : $urandom_range(70000));
            write_reg(REG_DRY_MAX, $urandom_range(1) ? rand_q32() : $urandom_range(131072));
            write_reg(REG_FULL_MAX, $urandom_range(1) ? rand_q32() : $urandom_range(131072));
            write_reg(REG_THR_MIN, $urandom_range(1) ? rand_q32()
                                   : $urandom_range(20000) - 10000);
            n = 0;
            if (ph == 4) begin
                fork
                    begin
                        hold_out = 1'b1;
                        repeat (3000) @(posedge clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            while (n < 125) begin
                send_request(rand_req());
                n++;
                if (ph == 5 && n == 60) drain();
            end
            drain();
        end

        if (mismatches == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/rlpt_pkg.sv
rtl/core/rlpt_datapath.sv
rtl/core/rlpt_ctrl.sv
rtl/core/rate_limited_pid_throttle_unit.sv
verif/tb_rate_limited_pid_throttle_unit.sv
